// File: rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int ID_W   = 8;
    localparam int SLOT_W = 3;
    localparam int RUN_W  = 9;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Markers held in the last-run register
    localparam logic [RUN_W-1:0] NONE_MARK = 9'h1FF;
    localparam logic [RUN_W-1:0] IDLE_MARK = 9'h100;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } req_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   run_id;
        logic              idle;
        logic [TIME_W-1:0] tick_time;
        logic [TIME_W-1:0] seg_start;
        logic              new_segment;
        logic              all_done;
    } rsp_item_t;

    // One slot as seen by the compare unit
    typedef struct packed {
        logic [TIME_W-1:0] arrive;
        logic [TIME_W-1:0] remain;
        logic [PRIO_W-1:0] prio;
    } cand_t;

    typedef struct packed {
        logic eligible;
        logic better;
    } cmp_res_t;

endpackage

// File: rtl/pps_cmp.sv
// Shared compare unit: tests one slot against the running best choice.
module pps_cmp (
    input  logic [pps_pkg::TIME_W-1:0] now,
    input  pps_pkg::cand_t             cand,
    input  logic                       found,
    input  logic [pps_pkg::PRIO_W-1:0] best_prio,
    output pps_pkg::cmp_res_t          res
);
    import pps_pkg::*;

    always_comb
    begin
        res.eligible = (cand.arrive <= now) && (cand.remain != '0);
        // strict greater keeps the lowest slot on equal priority
        res.better   = res.eligible && (!found || (cand.prio > best_prio));
    end

endmodule

// File: rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: slot table, scan sequencer, result register.
// Load: accepted while idle, writes the slot table, no result.
// Tick: streams the table through the registered read port and the compare unit, then
//   commits; requests wait until that commit, which waits while the result register is full.
// Reset clears slot valid bits, time, last-run marker and segment start at once;
//   a slot never loaded reads as empty.
module preemptive_priority_scheduler_unit #(
    parameter int SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pps_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pps_pkg::rsp_item_t rsp_data
);
    import pps_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;

    // Scan counter: addresses the table, counts to SLOTS to close the scan
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;

    // Slot table memories and their valid bits
    logic [TIME_W-1:0] arrive_mem [SLOTS];
    logic [TIME_W-1:0] remain_mem [SLOTS];
    logic [PRIO_W-1:0] prio_mem   [SLOTS];
    logic [ID_W-1:0]   id_mem     [SLOTS];
    logic [SLOTS-1:0]  slot_vld_reg, slot_vld_next;

    // Registered read port
    logic [TIME_W-1:0] rd_arrive_reg;
    logic [TIME_W-1:0] rd_remain_reg;
    logic [PRIO_W-1:0] rd_prio_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic              rd_vld_reg;
    logic              rd_live_reg, rd_live_next;
    logic [IDX_W-1:0]  rd_slot_reg;
    logic [IDX_W-1:0]  rd_addr;

    // Running best choice of the current scan
    logic              found_reg, found_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]  pick_slot_reg, pick_slot_next;
    logic [ID_W-1:0]   pick_id_reg, pick_id_next;
    logic [TIME_W-1:0] pick_remain_reg, pick_remain_next;
    logic              done_acc_reg, done_acc_next;

    // Scheduler time and segment state
    logic [TIME_W-1:0] now_reg, now_next;
    logic [RUN_W-1:0]  last_run_reg, last_run_next;
    logic [TIME_W-1:0] seg_reg, seg_next;

    // Result register
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_data_reg, rsp_data_next;

    logic             req_fire;
    logic             load_wr;
    logic             commit;
    logic [IDX_W-1:0] load_addr;
    cand_t            cand;
    cmp_res_t         cmp_res;
    logic [RUN_W-1:0] choice;
    logic             fresh;

    // Accept only between ticks; loads and ticks alike wait while a scan runs
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign load_addr = IDX_W'(req_data.slot);
    // Loads beyond the table are dropped
    assign load_wr   = req_fire && (req_data.command == CMD_LOAD)
                       && (32'(req_data.slot) < SLOTS);

    // Commit only when the result register is free or being emptied this cycle
    assign commit = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);

    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    // A slot never loaded reads as empty, so it neither runs nor blocks all_done
    assign cand.arrive = rd_arrive_reg;
    assign cand.remain = rd_vld_reg ? rd_remain_reg : '0;
    assign cand.prio   = rd_prio_reg;

    pps_cmp u_cmp (
        .now       (now_reg),
        .cand      (cand),
        .found     (found_reg),
        .best_prio (best_prio_reg),
        .res       (cmp_res)
    );

    // An idle tick counts as a choice of its own
    assign choice = found_reg ? RUN_W'(pick_slot_reg) : IDLE_MARK;
    assign fresh  = (choice != last_run_reg);

    always_comb
    begin
        state_next       = state_reg;
        scan_cnt_next    = scan_cnt_reg;
        slot_vld_next    = slot_vld_reg;
        rd_live_next     = 1'b0;
        found_next       = found_reg;
        best_prio_next   = best_prio_reg;
        pick_slot_next   = pick_slot_reg;
        pick_id_next     = pick_id_reg;
        pick_remain_next = pick_remain_reg;
        done_acc_next    = done_acc_reg;
        now_next         = now_reg;
        last_run_next    = last_run_reg;
        seg_next         = seg_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_data_next    = rsp_data_reg;

        if (load_wr)
        begin
            slot_vld_next[load_addr] = 1'b1;
        end

        // Fold in the slot read on the previous cycle
        if (rd_live_reg)
        begin
            done_acc_next = done_acc_reg && (cand.remain == '0);
            if (cmp_res.better)
            begin
                found_next       = 1'b1;
                best_prio_next   = cand.prio;
                pick_slot_next   = rd_slot_reg;
                pick_id_next     = rd_id_reg;
                pick_remain_next = cand.remain;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req_data.command == CMD_TICK))
                begin
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    done_acc_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(SLOTS))
                begin
                    // last slot is compared on this edge
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_live_next  = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    if (fresh)
                    begin
                        seg_next = now_reg;
                    end
                    last_run_next             = choice;
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.run_id      = found_reg ? pick_id_reg : '0;
                    rsp_data_next.idle        = !found_reg;
                    rsp_data_next.tick_time   = now_reg;
                    rsp_data_next.seg_start   = fresh ? now_reg : seg_reg;
                    rsp_data_next.new_segment = fresh;
                    rsp_data_next.all_done    = done_acc_reg;
                    now_next                  = now_reg + TIME_W'(1);
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot table: one write port (load or decrement), one registered read port
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            id_mem[load_addr]     <= req_data.proc_id;
            arrive_mem[load_addr] <= req_data.arrival;
            remain_mem[load_addr] <= req_data.burst;
            prio_mem[load_addr]   <= req_data.prio;
        end
        else if (commit && found_reg)
        begin
            remain_mem[pick_slot_reg] <= pick_remain_reg - TIME_W'(1);
        end
        rd_arrive_reg <= arrive_mem[rd_addr];
        rd_remain_reg <= remain_mem[rd_addr];
        rd_prio_reg   <= prio_mem[rd_addr];
        rd_id_reg     <= id_mem[rd_addr];
        rd_vld_reg    <= slot_vld_reg[rd_addr];
        rd_slot_reg   <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_cnt_reg    <= '0;
            slot_vld_reg    <= '0;
            rd_live_reg     <= 1'b0;
            found_reg       <= 1'b0;
            best_prio_reg   <= '0;
            pick_slot_reg   <= '0;
            pick_id_reg     <= '0;
            pick_remain_reg <= '0;
            done_acc_reg    <= 1'b1;
            now_reg         <= '0;
            last_run_reg    <= NONE_MARK;
            seg_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_cnt_reg    <= scan_cnt_next;
            slot_vld_reg    <= slot_vld_next;
            rd_live_reg     <= rd_live_next;
            found_reg       <= found_next;
            best_prio_reg   <= best_prio_next;
            pick_slot_reg   <= pick_slot_next;
            pick_id_reg     <= pick_id_next;
            pick_remain_reg <= pick_remain_next;
            done_acc_reg    <= done_acc_next;
            now_reg         <= now_next;
            last_run_reg    <= last_run_next;
            seg_reg         <= seg_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Result payload holds until the next commit
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Scan counter never runs past the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(SLOTS))
        else $error("scan counter beyond table");

    // Each commit advances time by exactly one tick
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> now_reg == TIME_W'($past(now_reg) + TIME_W'(1)))
        else $error("time did not advance by one on commit");

    // A new segment begins at the current tick
    a_seg_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.new_segment |-> rsp_data.seg_start == rsp_data.tick_time)
        else $error("new segment does not start at this tick");

    // With no work left nothing can run
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.all_done |-> rsp_data.idle && (rsp_data.run_id == '0))
        else $error("process ran although all work was done");

endmodule

// File: tb/tb_preemptive_priority_scheduler_unit.sv
// Self-checking testbench for the preemptive priority scheduler unit.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_unit;

    import pps_pkg::*;

    localparam int SLOT_COUNT      = 8;
    localparam int RANDOM_ITEMS    = 500;    // per flow-control phase
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;   // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES   = 4 * (SLOT_COUNT + 2);

    // ------------------------------------------------------------------
    // Scheduler scoreboard: mirrors the slot table, time and segment
    // tracking, and holds the tick results still owed by the block.
    // ------------------------------------------------------------------
    class sched_scoreboard;
        logic [TIME_W-1:0] arrive_tbl [SLOT_COUNT];
        logic [TIME_W-1:0] remain_tbl [SLOT_COUNT];
        logic [PRIO_W-1:0] prio_tbl   [SLOT_COUNT];
        logic [ID_W-1:0]   id_tbl     [SLOT_COUNT];
        logic [TIME_W-1:0] clock_now;
        logic [RUN_W-1:0]  last_choice;
        logic [TIME_W-1:0] segment_origin;
        rsp_item_t         ticks_due [$];
        int                failures;
        int                loads_seen;
        int                ticks_seen;
        int                idle_ticks;
        int                segments;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                arrive_tbl[i] = '0;
                remain_tbl[i] = '0;
                prio_tbl[i]   = '0;
                id_tbl[i]     = '0;
            end
            clock_now      = '0;
            last_choice    = NONE_MARK;
            segment_origin = '0;
            failures       = 0;
            loads_seen     = 0;
            ticks_seen     = 0;
            idle_ticks     = 0;
            segments       = 0;
        endfunction

        function int pending();
            return ticks_due.size();
        endfunction

        // Apply one accepted request; a tick queues the result it must produce.
        function void note_request(req_item_t r);
            bit               found;
            int               pick;
            bit               done;
            logic [RUN_W-1:0] choice;
            rsp_item_t        want;
            found = 1'b0;
            pick  = 0;
            done  = 1'b1;
            if (r.command == CMD_LOAD)
            begin
                loads_seen++;
                if (int'(r.slot) < SLOT_COUNT)
                begin
                    id_tbl[r.slot]     = r.proc_id;
                    arrive_tbl[r.slot] = r.arrival;
                    remain_tbl[r.slot] = r.burst;
                    prio_tbl[r.slot]   = r.prio;
                end
                return;
            end
            ticks_seen++;
            // Strictly greater keeps the lowest slot on a tie
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (remain_tbl[i] != '0)
                    done = 1'b0;
                if (arrive_tbl[i] <= clock_now && remain_tbl[i] != '0)
                begin
                    if (!found || prio_tbl[i] > prio_tbl[pick])
                    begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
            end
            choice = found ? RUN_W'(pick) : IDLE_MARK;
            want.new_segment = (choice != last_choice);
            if (want.new_segment)
            begin
                segment_origin = clock_now;
                segments++;
            end
            last_choice    = choice;
            want.run_id    = found ? id_tbl[pick] : '0;
            want.idle      = !found;
            want.tick_time = clock_now;
            want.seg_start = segment_origin;
            want.all_done  = done;
            ticks_due.push_back(want);
            if (found)
                remain_tbl[pick] = remain_tbl[pick] - 1'b1;
            else
                idle_ticks++;
            clock_now = clock_now + 1'b1;
        endfunction

        // Compare one delivered result with the oldest owed tick result.
        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (ticks_due.size() == 0)
            begin
                $error("result arrived with no tick outstanding (run_id %0d)", got.run_id);
                failures++;
                return;
            end
            want = ticks_due.pop_front();
            if (got.run_id !== want.run_id)
            begin
                $error("run_id: expected %0d, actual %0d", want.run_id, got.run_id);
                failures++;
            end
            if (got.idle !== want.idle)
            begin
                $error("idle: expected %0d, actual %0d", want.idle, got.idle);
                failures++;
            end
            if (got.tick_time !== want.tick_time)
            begin
                $error("tick_time: expected %0d, actual %0d", want.tick_time, got.tick_time);
                failures++;
            end
            if (got.seg_start !== want.seg_start)
            begin
                $error("seg_start: expected %0d, actual %0d", want.seg_start, got.seg_start);
                failures++;
            end
            if (got.new_segment !== want.new_segment)
            begin
                $error("new_segment: expected %0d, actual %0d",
                       want.new_segment, got.new_segment);
                failures++;
            end
            if (got.all_done !== want.all_done)
            begin
                $error("all_done: expected %0d, actual %0d", want.all_done, got.all_done);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block itself
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_data;

    // Flow-control knobs, changed by the stimulus process between phases
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    bit        hold_off_request = 1'b0;

    sched_scoreboard sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    preemptive_priority_scheduler_unit #(
        .SLOTS (SLOT_COUNT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Note the request
    // before checking the result; a tick's own result always comes later.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req_data);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp_data);
        end
    end

    // Watchdog: give up once nothing has transferred on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, sb.pending());
        $display("** preemptive_priority_scheduler_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result-side ready: random stalls at the phase's rate, plus a long
    // hold-off on request, counted down here so the sender keeps pushing
    // and the block has to back up into its request side.
    // ------------------------------------------------------------------
    initial
    begin : rsp_ready_drive
        int hold_left;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (int'($urandom_range(0, 99)) < rx_stall_pct)
                rsp_ready <= 1'b0;
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request builders and driver
    // ------------------------------------------------------------------
    function automatic req_item_t load_cmd(int s, int id, int arr, int len, int pr);
        req_item_t r;
        r.command = CMD_LOAD;
        r.slot    = SLOT_W'(s);
        r.proc_id = ID_W'(id);
        r.arrival = TIME_W'(arr);
        r.burst   = TIME_W'(len);
        r.prio    = PRIO_W'(pr);
        return r;
    endfunction

    function automatic req_item_t tick_cmd();
        req_item_t r;
        r         = req_item_t'($urandom());
        r.command = CMD_TICK;
        // The load fields ride along unused; give them random bits
        r.arrival = TIME_W'($urandom());
        r.burst   = TIME_W'($urandom());
        return r;
    endfunction

    // Random load aimed at the present time so that slots actually compete;
    // a minority use fully random arrival and burst to exercise every bit.
    function automatic req_item_t random_load();
        int arr;
        int len;
        int pr;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            arr = int'(sb.clock_now) + $urandom_range(0, 12) - 6;
        else
            arr = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            len = $urandom_range(1, 6);
        else if (pick < 90)
            len = 0;
        else
            len = $urandom_range(0, 65535);
        pr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        return load_cmd($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, 255),
                        arr, len, pr);
    endfunction

    // Offer one request; entered and left at a falling edge
    task automatic send_request(input req_item_t r);
        while (int'($urandom_range(0, 99)) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(tick_cmd());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        req_valid = 1'b0;
        req_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first tick on an empty table, zero burst, future arrival,
        // ties on the lowest priorities, reload over unfinished work.
        send_ticks(1);
        send_request(load_cmd(0, 255, 0, 0, 255));
        send_ticks(1);
        send_request(load_cmd(7, 165, 65535, 65535, 0));
        send_request(load_cmd(1, 1, 0, 2, 1));
        send_request(load_cmd(2, 2, 0, 2, 1));
        send_request(load_cmd(3, 3, 5, 1, 0));
        send_ticks(6);
        send_request(load_cmd(1, 90, 0, 3, 0));
        send_request(load_cmd(4, 4, 0, 1, 0));
        send_ticks(5);
        send_request(load_cmd(7, 255, 0, 1, 255));
        send_ticks(2);

        // Random phases: free flow with one long result hold-off, then
        // sender gaps, result stalls, and light stalls on both sides.
        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 8 : 0;
            rx_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 8 : 0;
            if (phase == 0)
                hold_off_request = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 40)
                    send_request(random_load());
                else
                    send_request(tick_cmd());
            end
        end
        req_valid <= 1'b0;

        // Drain, then leave room for any stray result
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d ticks (%0d idle, %0d segments),",
                 sb.loads_seen, sb.ticks_seen, sb.idle_ticks, sb.segments);
        $display("under free flow, sender gaps, result stalls, both, and one long hold-off.");
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** preemptive_priority_scheduler_unit: PASSED **");
        else
            $display("** preemptive_priority_scheduler_unit: FAILED **");
        $finish;
    end

endmodule
